// ===== rtl/quoted_argument_tokenizer_assert.svh =====
// assertion macros used by the tokenizer bundle queue
`ifndef QUOTED_ARGUMENT_TOKENIZER_ASSERT_SVH
`define QUOTED_ARGUMENT_TOKENIZER_ASSERT_SVH

// plain invariant checked at every clock edge out of reset
`define QAT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("qat invariant violated");

// same-cycle implication
`define QAT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qat implication violated");

// next-cycle implication
`define QAT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qat next-cycle implication violated");

`endif

// ===== rtl/qat_pkg.sv =====
// shared types, constants and helpers of the argument tokenizer
package qat_pkg;

	localparam int MAX_LINE_CHARS = 65535;
	localparam int CC_W           = $clog2(MAX_LINE_CHARS + 1);
	localparam int NSLOTS         = 4;
	localparam int Q_DEPTH        = 4;
	localparam int Q_PTR_W        = $clog2(Q_DEPTH);
	localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_END  = 2'd1,
		KIND_DROP = 2'd2,
		KIND_DONE = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       line_end;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  char_value;
		logic [7:0]  arg_number;
		logic [15:0] consumed_count;
		logic        run_last;
	} out_item_t;

	// all results caused by one input byte, in emission order
	typedef struct packed {
		logic [NSLOTS-1:0]            slot_valid;
		out_item_t [NSLOTS-1:0]       slot;
	} bundle_t;

	function automatic logic [7:0] sat_inc8(input logic [7:0] v);
		return (v != 8'hFF) ? v + 8'd1 : v;
	endfunction

	function automatic logic [15:0] report_count(input logic [CC_W-1:0] v);
		if (32'(v) > 32'hFFFF)
			return 16'hFFFF;
		else
			return 16'(v);
	endfunction

endpackage

// ===== rtl/qat_front.sv =====
// front end: accepts bytes, tracks quoting and builds the result bundle per byte
module qat_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  qat_pkg::in_item_t in_data,
	input  logic [7:0]        args_limit,
	input  logic              q_full,
	output logic              push,
	output qat_pkg::bundle_t  push_data
);

	logic                     sq_q, dq_q, held_q, open_q, lim_q;
	logic [7:0]               argc_q;
	logic [qat_pkg::CC_W-1:0] char_q;

	logic                     sq_n, dq_n, held_n, open_n, lim_n;
	logic [7:0]               argc_n;
	logic [qat_pkg::CC_W-1:0] char_n;
	logic [7:0]               c;
	logic                     last, is_sq, is_dq, is_quote, blank, esc, stop;
	logic [7:0]               argc1;
	qat_pkg::bundle_t         b;
	logic                     accept;

	assign accept   = in_valid && !q_full;
	assign in_stall = q_full;
	assign c        = in_data.char_code;
	assign last     = in_data.line_end;
	assign is_sq    = (c == qat_pkg::CH_SQUOTE);
	assign is_dq    = (c == qat_pkg::CH_DQUOTE);
	assign is_quote = is_sq || is_dq;
	assign blank    = (c == qat_pkg::CH_SPACE) || (c >= qat_pkg::CH_TAB && c <= qat_pkg::CH_CR);

	always_comb begin
		b      = '0;
		sq_n   = sq_q;
		dq_n   = dq_q;
		held_n = 1'b0;
		open_n = open_q;
		argc_n = argc_q;
		lim_n  = lim_q;
		char_n = char_q;
		argc1  = argc_q;
		esc    = held_q && is_quote;
		stop   = 1'b0;
		for (int i = 0; i < qat_pkg::NSLOTS; i++) begin
			b.slot[i].kind = qat_pkg::KIND_CHAR;
		end

		if (lim_q) begin
			// line already finished by the limit: swallow bytes until line end
			if (last) begin
				sq_n   = 1'b0;
				dq_n   = 1'b0;
				open_n = 1'b0;
				argc_n = '0;
				char_n = '0;
				lim_n  = 1'b0;
			end
		end else begin
			if (char_q < qat_pkg::CC_W'(qat_pkg::MAX_LINE_CHARS))
				char_n = char_q + 1'b1;

			// held backslash comes out unless it escapes a quote
			if (held_q && !is_quote) begin
				b.slot_valid[0]      = 1'b1;
				b.slot[0].kind       = qat_pkg::KIND_CHAR;
				b.slot[0].char_value = qat_pkg::CH_BSLASH;
				b.slot[0].arg_number = argc_q;
				open_n               = 1'b1;
			end

			if (is_sq && !dq_q && !esc) begin
				sq_n = !sq_q;
			end else if (is_dq && !sq_q && !esc) begin
				dq_n = !dq_q;
			end else if (blank && !dq_q && !sq_q) begin
				if (open_n) begin
					b.slot_valid[1]      = 1'b1;
					b.slot[1].kind       = qat_pkg::KIND_END;
					b.slot[1].arg_number = argc_q;
					argc1                = qat_pkg::sat_inc8(argc_q);
					open_n               = 1'b0;
				end
			end else if (c == qat_pkg::CH_BSLASH && !last) begin
				held_n = 1'b1;
			end else begin
				b.slot_valid[1]      = 1'b1;
				b.slot[1].kind       = qat_pkg::KIND_CHAR;
				b.slot[1].char_value = c;
				b.slot[1].arg_number = argc_q;
				open_n               = 1'b1;
			end

			argc_n = argc1;
			stop   = last || (args_limit != 8'd0 && argc1 >= args_limit);
			if (stop) begin
				if (open_n) begin
					b.slot_valid[2]      = 1'b1;
					b.slot[2].arg_number = argc1;
					if (dq_n || sq_n) begin
						b.slot[2].kind = qat_pkg::KIND_DROP;
					end else begin
						b.slot[2].kind = qat_pkg::KIND_END;
						argc_n         = qat_pkg::sat_inc8(argc1);
					end
				end
				b.slot_valid[3]          = 1'b1;
				b.slot[3].kind           = qat_pkg::KIND_DONE;
				b.slot[3].arg_number     = argc_n;
				b.slot[3].consumed_count = qat_pkg::report_count(char_n);
				if (last) begin
					sq_n   = 1'b0;
					dq_n   = 1'b0;
					held_n = 1'b0;
					open_n = 1'b0;
					argc_n = '0;
					char_n = '0;
				end else begin
					lim_n = 1'b1;
				end
			end
		end

		// flag the final result of this byte
		if (b.slot_valid[3])
			b.slot[3].run_last = 1'b1;
		else if (b.slot_valid[2])
			b.slot[2].run_last = 1'b1;
		else if (b.slot_valid[1])
			b.slot[1].run_last = 1'b1;
		else if (b.slot_valid[0])
			b.slot[0].run_last = 1'b1;
	end

	assign push      = accept && (b.slot_valid != '0);
	assign push_data = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q   <= 1'b0;
			dq_q   <= 1'b0;
			held_q <= 1'b0;
			open_q <= 1'b0;
			lim_q  <= 1'b0;
			argc_q <= '0;
			char_q <= '0;
		end else if (accept) begin
			sq_q   <= sq_n;
			dq_q   <= dq_n;
			held_q <= held_n;
			open_q <= open_n;
			lim_q  <= lim_n;
			argc_q <= argc_n;
			char_q <= char_n;
		end
	end

endmodule

// ===== rtl/qat_fifo.sv =====
// short queue of result bundles between the front and back ends
`include "quoted_argument_tokenizer_assert.svh"

module qat_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  qat_pkg::bundle_t push_data,
	input  logic             pop,
	output qat_pkg::bundle_t head,
	output logic             full,
	output logic             empty
);

	qat_pkg::bundle_t            mem_q [qat_pkg::Q_DEPTH];
	logic [qat_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [qat_pkg::Q_CNT_W-1:0] count_q;

	assign full  = (count_q == qat_pkg::Q_CNT_W'(qat_pkg::Q_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`QAT_ASSERT(a_count_bound, count_q <= qat_pkg::Q_CNT_W'(qat_pkg::Q_DEPTH))
	`QAT_ASSERT(a_ptr_gap, (wr_ptr_q - rd_ptr_q) == count_q[qat_pkg::Q_PTR_W-1:0])
	`QAT_ASSERT_IMP(a_no_underflow, pop, !empty)
	`QAT_ASSERT_NXT(a_fill_step, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

// ===== rtl/qat_back.sv =====
// back end: unpacks each bundle into single results through the output register
module qat_back (
	input  logic               clk,
	input  logic               arst_n,
	input  qat_pkg::bundle_t   head,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output qat_pkg::out_item_t out_data
);

	logic [qat_pkg::NSLOTS-1:0] taken_q;
	logic [qat_pkg::NSLOTS-1:0] rem, pick;
	logic                       out_valid_q;
	qat_pkg::out_item_t         out_q;
	qat_pkg::out_item_t         sel_item;
	logic                       load, final_slot;

	assign rem = head.slot_valid & ~taken_q;

	// lowest pending slot first
	always_comb begin
		pick     = '0;
		sel_item = head.slot[0];
		for (int i = qat_pkg::NSLOTS - 1; i >= 0; i--) begin
			if (rem[i]) begin
				pick     = '0;
				pick[i]  = 1'b1;
				sel_item = head.slot[i];
			end
		end
	end

	assign load       = (!out_valid_q || !out_stall) && !empty;
	assign final_slot = ((rem & ~pick) == '0);
	assign pop        = load && final_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			taken_q     <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (pop)
				taken_q <= '0;
			else if (load)
				taken_q <= taken_q | pick;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= sel_item;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/quoted_argument_tokenizer.sv =====
// top level: splits a byte stream into shell-style arguments
// path: the results of a byte pass through the bundle queue, then the output register
// throughput: one byte per cycle while the queue is not full; results leave one per cycle
//   while out_stall is low, and a four-entry bundle queue absorbs bytes with many results
// reset: arst_n clears quoting state, counters, queue and output valid at once; no clear pass
module quoted_argument_tokenizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  qat_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output qat_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);

	logic [7:0]       args_limit_q;
	logic             push, pop, q_full, q_empty;
	qat_pkg::bundle_t push_data, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			args_limit_q <= '0;
		else if (cfg_valid && cfg_ready)
			args_limit_q <= cfg_data;
	end

	qat_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.args_limit (args_limit_q),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	qat_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	qat_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
